/* rtl/mqrb_pkg.sv */
// Shared types and constants for the multi-queue byte ring buffer.
package mqrb_pkg;

  localparam int QUEUE_COUNT_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 256;

  localparam int BYTE_W   = 8;
  localparam int OPCODE_W = 2;
  localparam int QSEL_W   = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  // Status of one operation while its store access is in flight
  typedef struct packed {
    logic rd_hit;
    logic was_empty;
    logic overrun;
  } op_status_t;

endpackage

/* rtl/mqrb_store.sv */
// Single-port byte store with registered read.
module mqrb_store #(
  parameter int DEPTH = mqrb_pkg::QUEUE_COUNT_DEF * mqrb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      addr,
  input  logic [mqrb_pkg::BYTE_W-1:0]   wr_data,
  output logic [mqrb_pkg::BYTE_W-1:0]   rd_data
);
  import mqrb_pkg::*;

  logic [BYTE_W-1:0] store_r [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_r[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/multi_queue_byte_ring_buffer_unit.sv */
// Top level of the multi-queue byte ring buffer: pointers, store access and result register.
//
// QUEUE_COUNT byte FIFOs of QUEUE_DEPTH entries share one single-port store of
// QUEUE_COUNT*QUEUE_DEPTH bytes; queue q owns the slice starting at q*QUEUE_DEPTH.
// Head and tail pointers live in flops and reset to zero, so every queue is empty
// after reset; the store itself is not cleared and needs no clearing pass. One beat
// is accepted per cycle while no result is held downstream: the pointers are read
// and updated in the accept cycle and the store is written (write) or read (read of
// a non-empty queue) at the same edge. A result passes through stage one, which
// holds the store's registered read, and then through the result register before it
// is presented. Writes are not checked for full: a write that
// brings the tail onto the head reports overrun and leaves the queue empty. A read
// of an empty queue returns zero and moves nothing. A queue index at or above
// QUEUE_COUNT changes nothing and reports was_empty with zero data. Since pointers
// update in the accept cycle and the store handles one access per cycle, beats on
// the same queue may follow each other in consecutive cycles.
module multi_queue_byte_ring_buffer_unit #(
  parameter int QUEUE_COUNT = mqrb_pkg::QUEUE_COUNT_DEF,
  parameter int QUEUE_DEPTH = mqrb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mqrb_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [mqrb_pkg::QSEL_W-1:0]   in_queue_index,
  input  logic [mqrb_pkg::BYTE_W-1:0]   in_write_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mqrb_pkg::BYTE_W-1:0]   out_read_byte,
  output logic                          out_was_empty,
  output logic                          out_overrun
);
  import mqrb_pkg::*;

  localparam int PW         = $clog2(QUEUE_DEPTH);
  localparam int QIW        = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int STORE_DEPTH = QUEUE_COUNT * QUEUE_DEPTH;
  localparam int AW         = $clog2(STORE_DEPTH);
  // One spare bit so that QUEUE_COUNT itself fits in the range compare
  localparam int SELW       = ((QIW > QSEL_W) ? QIW : QSEL_W) + 1;

  // Pointer flops, one head and one tail per queue
  logic [PW-1:0] head_r [QUEUE_COUNT];
  logic [PW-1:0] tail_r [QUEUE_COUNT];

  // Stage one: store access in flight
  logic       s1_valid_r;
  op_status_t s1_r;

  // Result register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_read_byte_r;
  logic              out_was_empty_r;
  logic              out_overrun_r;

  logic              in_accept;
  logic              s1_adv;
  opcode_t           op;
  logic              q_ok;
  logic [QIW-1:0]    qi;
  logic [PW-1:0]     head_cur;
  logic [PW-1:0]     tail_cur;
  logic [PW-1:0]     head_inc;
  logic [PW-1:0]     tail_inc;
  logic              empty;
  logic              do_write;
  logic              do_read;
  logic [PW-1:0]     mem_ptr;
  logic [AW-1:0]     mem_addr;
  logic [BYTE_W-1:0] mem_rd_data;
  op_status_t        s1_nxt;

  // Drain stage one whenever the result register is free or being taken
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_accept = in_valid && in_ready;

  assign op   = opcode_t'(in_opcode);
  assign q_ok = SELW'(in_queue_index) < SELW'(QUEUE_COUNT);
  assign qi   = QIW'(in_queue_index);

  always_comb begin
    head_cur = '0;
    tail_cur = '0;
    if (q_ok) begin
      head_cur = head_r[qi];
      tail_cur = tail_r[qi];
    end
  end

  // Advance with wrap at the queue depth
  assign head_inc = (head_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + PW'(1);
  assign tail_inc = (tail_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_cur + PW'(1);

  assign empty    = (head_cur == tail_cur);
  assign do_write = in_accept && q_ok && (op == OP_WRITE);
  assign do_read  = in_accept && q_ok && (op == OP_READ) && !empty;

  assign mem_ptr  = (op == OP_WRITE) ? tail_cur : head_cur;
  assign mem_addr = AW'(qi) * AW'(QUEUE_DEPTH) + AW'(mem_ptr);

  always_comb begin
    s1_nxt.rd_hit    = do_read;
    s1_nxt.was_empty = empty || !q_ok;
    s1_nxt.overrun   = q_ok && (op == OP_WRITE) && (tail_inc == head_cur);
  end

  mqrb_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (do_write),
    .rd_en   (do_read),
    .addr    (mem_addr),
    .wr_data (in_write_byte),
    .rd_data (mem_rd_data)
  );

  // Pointer updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else if (in_accept && q_ok) begin
      case (op)
        OP_WRITE: begin
          tail_r[qi] <= tail_inc;
        end
        OP_READ: begin
          if (!empty) begin
            head_r[qi] <= head_inc;
          end
        end
        OP_CLEAR: begin
          head_r[qi] <= '0;
          tail_r[qi] <= '0;
        end
        default: begin
          // query: hold pointers
        end
      endcase
    end
  end

  // Stage one control and status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
  end

  // Result register; zero the byte unless a real read took place
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_read_byte_r <= s1_r.rd_hit ? mem_rd_data : '0;
      out_was_empty_r <= s1_r.was_empty;
      out_overrun_r   <= s1_r.overrun;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_byte = out_read_byte_r;
  assign out_was_empty = out_was_empty_r;
  assign out_overrun   = out_overrun_r;

`ifndef SYNTHESIS
  // A read that returns data can never also report overrun or an empty queue
  a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !(s1_r.rd_hit && (s1_r.overrun || s1_r.was_empty)))
    else $error("read hit flagged together with overrun or empty");

  // A clear leaves both pointers of that queue at zero
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && q_ok && op == OP_CLEAR) |=>
      (head_r[$past(qi)] == '0 && tail_r[$past(qi)] == '0))
    else $error("queue pointers not cleared");

  // Input stalls only while a finished result waits downstream
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with free downstream stage");

  // Stage one always moves to the result register whenever it holds a beat
  // and the result register is not held
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !(out_valid_r && !out_ready)) |=> out_valid_r)
    else $error("stage one did not drain into result register");
`endif

endmodule

/* test/multi_queue_byte_ring_buffer_unit_test.sv */
// Testbench for the multi-queue byte ring buffer: directed table, random traffic, scoreboard.
`timescale 1ns / 100ps

module multi_queue_byte_ring_buffer_unit_test;
  import mqrb_pkg::*;

  localparam int QCOUNT        = QUEUE_COUNT_DEF;
  localparam int QDEPTH        = QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DIR_ROWS      = 24;

  // One result beat as the block presents it
  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              was_empty;
    logic              overrun;
  } ring_result_t;

  // One row of the directed table; rows with typed set carry their own expectation
  typedef struct packed {
    opcode_t           op;
    logic [QSEL_W-1:0] q;
    logic [BYTE_W-1:0] wb;
    logic [8:0]        reps;
    logic              typed;
    ring_result_t      res;
  } dir_row_t;

  localparam ring_result_t EMPTY_RES   = '{8'h00, 1'b1, 1'b0};
  localparam ring_result_t FILLED_RES  = '{8'h00, 1'b0, 1'b0};
  localparam ring_result_t OVERRUN_RES = '{8'h00, 1'b0, 1'b1};
  localparam ring_result_t PREDICTED   = '{8'h00, 1'b0, 1'b0};

  // Directed table: reset state, field extremes, every operation, read of an
  // empty queue, clear reporting the old state, pointer wrap and overrun on a full queue.
  dir_row_t dir_table [DIR_ROWS] = '{
    '{OP_QUERY, 3'd0, 8'h00, 9'd1,   1'b1, EMPTY_RES},   // everything empty after reset
    '{OP_READ,  3'd7, 8'hFF, 9'd1,   1'b1, EMPTY_RES},   // empty read returns zero
    '{OP_WRITE, 3'd0, 8'h00, 9'd1,   1'b1, EMPTY_RES},
    '{OP_WRITE, 3'd0, 8'hFF, 9'd1,   1'b1, FILLED_RES},
    '{OP_QUERY, 3'd0, 8'h3C, 9'd1,   1'b1, FILLED_RES},
    '{OP_READ,  3'd0, 8'h00, 9'd1,   1'b0, PREDICTED},
    '{OP_READ,  3'd0, 8'h00, 9'd1,   1'b0, PREDICTED},
    '{OP_READ,  3'd0, 8'h00, 9'd1,   1'b1, EMPTY_RES},
    '{OP_WRITE, 3'd7, 8'hA5, 9'd1,   1'b0, PREDICTED},
    '{OP_WRITE, 3'd3, 8'h5A, 9'd1,   1'b0, PREDICTED},
    '{OP_CLEAR, 3'd7, 8'h00, 9'd1,   1'b1, FILLED_RES},  // clear reports state before it
    '{OP_QUERY, 3'd7, 8'h00, 9'd1,   1'b1, EMPTY_RES},
    '{OP_READ,  3'd7, 8'h00, 9'd1,   1'b1, EMPTY_RES},
    '{OP_READ,  3'd3, 8'h00, 9'd1,   1'b0, PREDICTED},
    '{OP_CLEAR, 3'd4, 8'hC3, 9'd1,   1'b1, EMPTY_RES},
    '{OP_WRITE, 3'd2, 8'h01, 9'd255, 1'b0, PREDICTED},   // one short of full, tail at 255
    '{OP_QUERY, 3'd2, 8'h00, 9'd1,   1'b1, FILLED_RES},
    '{OP_WRITE, 3'd2, 8'hEE, 9'd1,   1'b1, OVERRUN_RES}, // tail wraps onto head
    '{OP_QUERY, 3'd2, 8'h00, 9'd1,   1'b1, EMPTY_RES},   // contents lost
    '{OP_READ,  3'd2, 8'h00, 9'd1,   1'b1, EMPTY_RES},
    '{OP_WRITE, 3'd2, 8'h80, 9'd1,   1'b1, EMPTY_RES},
    '{OP_READ,  3'd2, 8'h00, 9'd1,   1'b0, PREDICTED},
    '{OP_WRITE, 3'd5, 8'h55, 9'd3,   1'b0, PREDICTED},   // back-to-back on one queue
    '{OP_READ,  3'd5, 8'h00, 9'd3,   1'b0, PREDICTED}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OPCODE_W-1:0] in_opcode = '0;
  logic [QSEL_W-1:0]   in_queue_index = '0;
  logic [BYTE_W-1:0]   in_write_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_read_byte;
  logic                out_was_empty;
  logic                out_overrun;

  // Typed expectation riding along with the beat on the input channel
  logic                typed_valid = 1'b0;
  ring_result_t        typed_res = '0;

  // Knobs shared by the sender and the receiver
  logic                idle_on = 1'b0;
  logic                hold_req = 1'b0;
  logic                hold_done = 1'b0;

  // Predictor state: the queues' pointers and the shared byte store
  int                  head_ptr [QCOUNT];
  int                  tail_ptr [QCOUNT];
  logic [BYTE_W-1:0]   ring_store [QCOUNT*QDEPTH];

  ring_result_t        pending_results [$];
  int                  fail_count = 0;
  int                  beats_sent = 0;
  int                  cycle_count = 0;

  always #5 clk = ~clk;

  multi_queue_byte_ring_buffer_unit #(
    .QUEUE_COUNT(QCOUNT),
    .QUEUE_DEPTH(QDEPTH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_queue_index(in_queue_index),
    .in_write_byte (in_write_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_byte (out_read_byte),
    .out_was_empty (out_was_empty),
    .out_overrun   (out_overrun)
  );

  // Apply one operation to the predicted queues and return the result it causes
  function automatic ring_result_t apply_ring_op(input logic [OPCODE_W-1:0] op,
                                                 input logic [QSEL_W-1:0] q,
                                                 input logic [BYTE_W-1:0] wb);
    ring_result_t r;
    int           h;
    int           t;
    int           base;
    r = '0;
    r.was_empty = 1'b1;
    // an index past the last queue changes nothing and reports empty
    if (int'(q) < QCOUNT) begin
      h = head_ptr[q];
      t = tail_ptr[q];
      base = int'(q) * QDEPTH;
      r.was_empty = (h == t);
      case (opcode_t'(op))
        OP_WRITE: begin
          // no full check: landing the tail on the head drops the contents
          ring_store[base + t] = wb;
          t = (t + 1) % QDEPTH;
          tail_ptr[q] = t;
          r.overrun = (t == h);
        end
        OP_READ: begin
          // empty read returns zero and leaves the head alone
          if (h != t) begin
            r.read_byte = ring_store[base + h];
            head_ptr[q] = (h + 1) % QDEPTH;
          end
        end
        OP_CLEAR: begin
          head_ptr[q] = 0;
          tail_ptr[q] = 0;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Scoreboard: retire the result beat first, then record the input beat's prediction.
  // Both sample the handshake values that held at the edge.
  always @(posedge clk) begin : scoreboard
    ring_result_t want;
    ring_result_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no expectation waiting: read_byte %0h", out_read_byte);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_read_byte !== want.read_byte) begin
            $error("read_byte: expected %0h, actual %0h", want.read_byte, out_read_byte);
            fail_count++;
          end
          if (out_was_empty !== want.was_empty) begin
            $error("was_empty: expected %0b, actual %0b", want.was_empty, out_was_empty);
            fail_count++;
          end
          if (out_overrun !== want.overrun) begin
            $error("overrun: expected %0b, actual %0b", want.overrun, out_overrun);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        // run the predictor always so its state tracks typed rows too
        got = apply_ring_op(in_opcode, in_queue_index, in_write_byte);
        pending_results.push_back(typed_valid ? typed_res : got);
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off that lets the block fill up
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (rst_n && idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one beat, optionally after an idle burst, and hold it until accepted
  task automatic send_beat(input opcode_t op, input logic [QSEL_W-1:0] q,
                           input logic [BYTE_W-1:0] wb, input logic typed,
                           input ring_result_t res);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_queue_index <= q;
    in_write_byte  <= wb;
    typed_valid    <= typed;
    typed_res      <= res;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Mixed traffic concentrated on two queues so they build up depth
  task automatic run_mixed(input int len);
    logic [QSEL_W-1:0] qa;
    logic [QSEL_W-1:0] qb;
    logic [QSEL_W-1:0] q;
    opcode_t           op;
    int                pick;
    qa = QSEL_W'($urandom_range(0, QCOUNT - 1));
    qb = QSEL_W'($urandom_range(0, QCOUNT - 1));
    repeat (len) begin
      q = $urandom_range(0, 1) ? qa : qb;
      if ($urandom_range(0, 19) == 0) q = QSEL_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      op = (pick < 42) ? OP_WRITE : (pick < 84) ? OP_READ : (pick < 94) ? OP_QUERY : OP_CLEAR;
      send_beat(op, q, BYTE_W'($urandom_range(0, 255)), 1'b0, PREDICTED);
    end
  endtask

  // Clear a queue and write it around the ring; the longer runs hit the overrun
  task automatic run_fill();
    logic [QSEL_W-1:0] q;
    q = QSEL_W'($urandom_range(0, QCOUNT - 1));
    send_beat(OP_CLEAR, q, BYTE_W'($urandom_range(0, 255)), 1'b0, PREDICTED);
    repeat ($urandom_range(QDEPTH - 6, QDEPTH + 4))
      send_beat(OP_WRITE, q, BYTE_W'($urandom_range(0, 255)), 1'b0, PREDICTED);
    repeat ($urandom_range(0, 12))
      send_beat(OP_READ, q, BYTE_W'($urandom_range(0, 255)), 1'b0, PREDICTED);
  endtask

  initial begin : stimulus
    int  start;
    int  done_cnt;
    bit  paused_once;
    paused_once = 1'b0;
    for (int i = 0; i < QCOUNT; i++) begin
      head_ptr[i] = 0;
      tail_ptr[i] = 0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, back to back with no idling
    foreach (dir_table[i]) begin
      for (int r = 0; r < int'(dir_table[i].reps); r++)
        send_beat(dir_table[i].op, dir_table[i].q, dir_table[i].wb + BYTE_W'(r),
                  dir_table[i].typed, dir_table[i].res);
    end

    // Random part, in segments; idling is switched per segment and off near the end
    start = beats_sent;
    done_cnt = 0;
    while (done_cnt < RANDOM_ITEMS) begin
      if (RANDOM_ITEMS - done_cnt < 150) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      if (!hold_req && done_cnt > 500) begin
        // keep offering beats while the receiver holds off, so the input stalls
        hold_req <= 1'b1;
        run_mixed(80);
      end else if (!paused_once && done_cnt > 1000) begin
        wait_drained();
        paused_once = 1'b1;
      end else if ($urandom_range(0, 24) == 0 && RANDOM_ITEMS - done_cnt > 400) begin
        run_fill();
      end else begin
        run_mixed($urandom_range(8, 48));
      end
      done_cnt = beats_sent - start;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
